[design/chd_pkg.sv]
// Shared types, widths and constant tables for the compass heading pipeline.
`default_nettype none

package chd_pkg;

    // Default values of the top-level parameters.
    localparam int CORDIC_STAGES_DEF   = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 7;
    localparam int MAX_STAGES          = 24;

    // Fixed widths of the datapath.
    localparam int AXIS_W     = 16;
    localparam int GAIN_CODE_W = 3;
    localparam int GAIN_W     = 11;
    localparam int GAIN_FRAC  = 8;
    localparam int PROD_W     = 27;
    localparam int MAG_W      = PROD_W - GAIN_FRAC;
    localparam int SCALED_W   = MAG_W + 1;
    localparam int GUARD_BITS = 16;
    localparam int XW         = 38;
    localparam int ACC_FRAC   = 24;
    localparam int ZW         = 35;
    localparam int HEADING_W  = 16;

    localparam logic [GAIN_CODE_W-1:0] GAIN_CODE_RST = 3'd1;

    // Register map: REG_GAIN is matched against the top address bit.
    localparam int  PADDR_W   = 3;
    localparam logic REG_GAIN = 1'b0;

    localparam logic signed [ZW-1:0] Z_HALF_TURN = ZW'(64'd180 << ACC_FRAC);
    localparam logic [ZW-1:0]        Z_FULL_TURN = ZW'(64'd360 << ACC_FRAC);

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } cordic_t;

    // Axis gain in unsigned Q3.8.
    function automatic logic [GAIN_W-1:0] gain_q8(input logic [GAIN_CODE_W-1:0] code);
        logic [GAIN_W-1:0] g;
        unique case (code)
            3'd0:    g = 11'd187;
            3'd1:    g = 11'd236;
            3'd2:    g = 11'd312;
            3'd3:    g = 11'd389;
            3'd4:    g = 11'd581;
            3'd5:    g = 11'd655;
            3'd6:    g = 11'd776;
            3'd7:    g = 11'd1114;
            default: g = 11'd236;
        endcase
        return g;
    endfunction

    // atan(2^-idx) in degrees with 24 fraction bits.
    function automatic logic signed [ZW-1:0] atan_deg(input int idx);
        logic signed [ZW-1:0] a;
        case (idx)
            0:       a = ZW'(754974720);
            1:       a = ZW'(445687602);
            2:       a = ZW'(235489088);
            3:       a = ZW'(119537938);
            4:       a = ZW'(60000934);
            5:       a = ZW'(30029717);
            6:       a = ZW'(15018523);
            7:       a = ZW'(7509720);
            8:       a = ZW'(3754917);
            9:       a = ZW'(1877466);
            10:      a = ZW'(938734);
            11:      a = ZW'(469367);
            12:      a = ZW'(234684);
            13:      a = ZW'(117342);
            14:      a = ZW'(58671);
            15:      a = ZW'(29335);
            16:      a = ZW'(14668);
            17:      a = ZW'(7334);
            18:      a = ZW'(3667);
            19:      a = ZW'(1833);
            20:      a = ZW'(917);
            21:      a = ZW'(458);
            22:      a = ZW'(229);
            23:      a = ZW'(115);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

[design/chd_scale.sv]
// Gain scaling of both axes and the half-turn pre-rotation, in three register stages.
`default_nettype none

module chd_scale
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [chd_pkg::AXIS_W-1:0]     mag_x,
    input  logic signed [chd_pkg::AXIS_W-1:0]     mag_y,
    input  logic [chd_pkg::GAIN_CODE_W-1:0]       gain_code,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output chd_pkg::cordic_t                      out_data
);
    import chd_pkg::*;

    logic                     s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                     s1_ready, s2_ready, s3_ready;
    logic [AXIS_W-1:0]        s1_ax_reg, s1_ay_reg, s1_ax_next, s1_ay_next;
    logic                     s1_nx_reg, s1_ny_reg;
    logic [GAIN_W-1:0]        s1_gain_reg;
    logic [PROD_W-1:0]        prod_x, prod_y;
    logic [MAG_W-1:0]         s2_mx_reg, s2_my_reg;
    logic                     s2_nx_reg, s2_ny_reg;
    logic signed [SCALED_W-1:0] sx, sy;
    logic signed [XW-1:0]     xw, yw;
    logic                     turn;
    cordic_t                  s3_data_reg, s3_data_next;

    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Sign and magnitude; the magnitude of -32768 still fits 16 unsigned bits.
    assign s1_ax_next = mag_x[AXIS_W-1] ? AXIS_W'(-mag_x) : AXIS_W'(mag_x);
    assign s1_ay_next = mag_y[AXIS_W-1] ? AXIS_W'(-mag_y) : AXIS_W'(mag_y);

    assign prod_x = PROD_W'(s1_ax_reg) * PROD_W'(s1_gain_reg);
    assign prod_y = PROD_W'(s1_ay_reg) * PROD_W'(s1_gain_reg);

    // Truncation toward zero is done on the magnitude, then the sign returns.
    always_comb
    begin
        sx = s2_nx_reg ? -signed'(SCALED_W'(s2_mx_reg)) : signed'(SCALED_W'(s2_mx_reg));
        sy = s2_ny_reg ? -signed'(SCALED_W'(s2_my_reg)) : signed'(SCALED_W'(s2_my_reg));
        xw = XW'(sx) <<< GUARD_BITS;
        yw = XW'(sy) <<< GUARD_BITS;
        turn = sx[SCALED_W-1];
        s3_data_next.x    = turn ? -xw : xw;
        s3_data_next.y    = turn ? -yw : yw;
        s3_data_next.z    = turn ? Z_HALF_TURN : '0;
        s3_data_next.zero = (s2_mx_reg == '0) && (s2_my_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_ax_reg   <= s1_ax_next;
            s1_ay_reg   <= s1_ay_next;
            s1_nx_reg   <= mag_x[AXIS_W-1];
            s1_ny_reg   <= mag_y[AXIS_W-1];
            s1_gain_reg <= gain_q8(gain_code);
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_mx_reg <= prod_x[GAIN_FRAC +: MAG_W];
            s2_my_reg <= prod_y[GAIN_FRAC +: MAG_W];
            s2_nx_reg <= s1_nx_reg;
            s2_ny_reg <= s1_ny_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_data_reg <= s3_data_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_data  = s3_data_reg;

endmodule

`default_nettype wire

[design/chd_cordic_stage.sv]
// One registered vectoring CORDIC micro-rotation.
`default_nettype none

module chd_cordic_stage
#(
    parameter int STAGE_IDX = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  chd_pkg::cordic_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output chd_pkg::cordic_t out_data
);
    import chd_pkg::*;

    localparam logic signed [ZW-1:0] ATAN = atan_deg(STAGE_IDX);

    logic                 valid_reg;
    cordic_t              data_reg, data_next;
    logic signed [XW-1:0] dx, dy;

    assign in_ready = !valid_reg || out_ready;

    // Both updates use the old x and y; the shifts round toward minus infinity.
    always_comb
    begin
        dx = in_data.y >>> STAGE_IDX;
        dy = in_data.x >>> STAGE_IDX;
        data_next.zero = in_data.zero;
        if (!in_data.y[XW-1])
        begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + ATAN;
        end
        else
        begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

[design/chd_finish.sv]
// Angle wrap, rounding to the output fraction and the output register.
`default_nettype none

module chd_finish
#(
    parameter int ANGLE_FRAC_BITS = chd_pkg::ANGLE_FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  chd_pkg::cordic_t                  in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [chd_pkg::HEADING_W-1:0]     heading
);
    import chd_pkg::*;

    localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int HW = ANGLE_FRAC_BITS + 10;
    localparam logic [ZW:0]   ROUND_HALF = (ZW+1)'(64'd1 << (SH - 1));
    localparam logic [HW-1:0] FULL_OUT   = HW'(64'd360 << ANGLE_FRAC_BITS);

    logic                 s1_valid_reg, s2_valid_reg;
    logic                 s1_ready, s2_ready;
    logic [ZW-1:0]        z_adj;
    logic [ZW:0]          z_round;
    logic [HW-1:0]        h_reg, h_next;
    logic                 zero_reg;
    logic [HW-1:0]        h_wrap;
    logic [HEADING_W-1:0] heading_reg, heading_next;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb
    begin
        z_adj   = in_data.z[ZW-1] ? ZW'(in_data.z) + Z_FULL_TURN : ZW'(in_data.z);
        z_round = (ZW+1)'(z_adj) + ROUND_HALF;
        h_next  = z_round[SH +: HW];
    end

    // A heading that rounds up to a full turn reads as zero.
    always_comb
    begin
        h_wrap = (h_reg >= FULL_OUT) ? h_reg - FULL_OUT : h_reg;
        heading_next = zero_reg ? '0 : HEADING_W'(h_wrap);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            h_reg    <= h_next;
            zero_reg <= in_data.zero;
        end
        if (s2_ready && s1_valid_reg)
        begin
            heading_reg <= heading_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign heading   = heading_reg;

endmodule

`default_nettype wire

[design/compass_heading_from_magnetometer_top.sv]
// Throughput: one word per clock cycle; every stage is a valid/ready register slice,
// so a stall holds each word in place and empty slots are filled while the output waits.
// The depth is set by the three scaling stages, one stage per CORDIC rotation and two finish stages.
// Reset clears all valid bits and sets gain_code to 1; there are no stores to clear.
`default_nettype none

module compass_heading_from_magnetometer_top
#(
    parameter int CORDIC_STAGES   = chd_pkg::CORDIC_STAGES_DEF,
    parameter int ANGLE_FRAC_BITS = chd_pkg::ANGLE_FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [chd_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [chd_pkg::AXIS_W-1:0] mag_x,
    input  logic signed [chd_pkg::AXIS_W-1:0] mag_y,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [chd_pkg::HEADING_W-1:0]     heading
);
    import chd_pkg::*;

    logic [GAIN_CODE_W-1:0] gain_code_reg, gain_code_next;
    logic                   gain_wr;

    cordic_t stg_data  [CORDIC_STAGES+1];
    logic    stg_valid [CORDIC_STAGES+1];
    logic    stg_ready [CORDIC_STAGES+1];

    assign pready  = 1'b1;
    assign gain_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_GAIN);
    assign gain_code_next = gain_wr ? pwdata[GAIN_CODE_W-1:0] : gain_code_reg;
    assign prdata  = (paddr[PADDR_W-1] == REG_GAIN) ? 32'(gain_code_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_code_reg <= GAIN_CODE_RST;
        end
        else
        begin
            gain_code_reg <= gain_code_next;
        end
    end

    chd_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mag_x     (mag_x),
        .mag_y     (mag_y),
        .gain_code (gain_code_reg),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_data  (stg_data[0])
    );

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        chd_cordic_stage
        #(
            .STAGE_IDX (i)
        )
        u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[i]),
            .in_ready  (stg_ready[i]),
            .in_data   (stg_data[i]),
            .out_valid (stg_valid[i+1]),
            .out_ready (stg_ready[i+1]),
            .out_data  (stg_data[i+1])
        );
    end

    chd_finish
    #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    )
    u_finish
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stg_valid[CORDIC_STAGES]),
        .in_ready  (stg_ready[CORDIC_STAGES]),
        .in_data   (stg_data[CORDIC_STAGES]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .heading   (heading)
    );

    // An empty output slice means every slice upstream can move, so input is taken.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while the output slice is empty");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(heading) < (32'd360 << ANGLE_FRAC_BITS)))
        else $error("heading at or beyond a full turn");

    a_gain_write: assert property (@(posedge clk) disable iff (!rst_n)
        gain_wr |=> (gain_code_reg == $past(pwdata[GAIN_CODE_W-1:0])))
        else $error("gain_code write not taken");

endmodule

`default_nettype wire
